>>> rtl/priority_retry_message_queue_macros.svh
// Assertion macros shared by the priority retry message queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PRIORITY_RETRY_MESSAGE_QUEUE_MACROS_SVH
`define PRIORITY_RETRY_MESSAGE_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prmq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prmq: next-cycle check failed");

`endif

>>> rtl/prmq_pkg.sv
// Package for the priority retry message queue: widths, codes and beat types.
// Depends on nothing; used by the front, back and top modules and by the testbench.
`timescale 1ns / 1ps

package prmq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int MAC_BITS      = 48;
	localparam int TIME_BITS     = 32;
	localparam int TRIES_BITS    = 4;
	localparam int TOTAL_BITS    = 32;
	localparam int FILL_BITS     = 5;
	localparam int QLIMIT_BITS   = 5;
	localparam int RLIMIT_BITS   = 4;
	localparam int CFG_DATA_BITS = 5;

	// Depths of the command queue and the result queue.
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	localparam logic [QLIMIT_BITS-1:0] QUEUE_LIMIT_RESET = 5'd16;
	localparam logic [RLIMIT_BITS-1:0] RETRY_LIMIT_RESET = 4'd3;
	localparam logic [TRIES_BITS-1:0]  TRIES_MAX         = 4'hF;

	typedef enum logic [1:0] {
		FUNC_ENQUEUE = 2'd0,
		FUNC_DEQUEUE = 2'd1,
		FUNC_RETRY   = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STATUS_QUEUED        = 3'd0,
		STATUS_QUEUED_DROP   = 3'd1,
		STATUS_POPPED        = 3'd2,
		STATUS_EMPTY         = 3'd3,
		STATUS_REQUEUED      = 3'd4,
		STATUS_EXHAUSTED     = 3'd5,
		STATUS_REFUSED_FULL  = 3'd6,
		STATUS_CLEARED       = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		CFG_QUEUE_LIMIT = 1'b0,
		CFG_RETRY_LIMIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		func_t                   func;
		logic [MAC_BITS-1:0]     node_mac;
		logic [PAYLOAD_BITS-1:0] payload_handle;
		logic                    urgent;
		logic [TRIES_BITS-1:0]   tries_so_far;
		logic [TIME_BITS-1:0]    now_ms;
	} in_item_t;

	typedef struct packed {
		status_t                 status;
		logic [MAC_BITS-1:0]     out_mac;
		logic [PAYLOAD_BITS-1:0] out_payload;
		logic [TIME_BITS-1:0]    out_time;
		logic [TRIES_BITS-1:0]   out_tries;
		logic                    out_urgent;
		logic [FILL_BITS-1:0]    fill_level;
		logic                    is_empty;
		logic                    is_full;
		logic [TOTAL_BITS-1:0]   dropped_total;
		logic [TOTAL_BITS-1:0]   received_total;
	} result_t;

	// One stored message.
	typedef struct packed {
		logic [MAC_BITS-1:0]     mac;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [TIME_BITS-1:0]    stamp;
		logic [TRIES_BITS-1:0]   tries;
		logic                    urgent;
	} entry_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		func_t  op;
		logic   retry_ok;
		entry_t entry;
	} cmd_t;

endpackage

>>> rtl/prmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the message entries of the queue.
`timescale 1ns / 1ps

module prmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/prmq_fifo.sv
// Small register-based FIFO used for the command and result queues.
// Depends on nothing.
`timescale 1ns / 1ps

module prmq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (level_q == FULL_LVL);
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push_ok && !pop_ok) begin
				level_q <= LVL_W'(level_q + 1'b1);
			end else if (pop_ok && !push_ok) begin
				level_q <= LVL_W'(level_q - 1'b1);
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/prmq_front.sv
// Front end: accepts input beats, decodes them into commands and queues them.
// Depends on prmq_pkg and prmq_fifo.
`timescale 1ns / 1ps

module prmq_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  prmq_pkg::in_item_t                   req,
	output logic                                 full,
	input  logic [prmq_pkg::RLIMIT_BITS-1:0]     retry_limit,
	output prmq_pkg::cmd_t                       cmd,
	output logic                                 cmd_valid,
	input  logic                                 cmd_take
);

	prmq_pkg::cmd_t                          cmd_in;
	logic [prmq_pkg::TRIES_BITS-1:0]         tries_inc;
	logic                                    cmd_empty;
	logic [$bits(prmq_pkg::cmd_t)-1:0]       cmd_vec;

	// Saturating retry count and the requeue decision.
	always_comb begin
		tries_inc = (req.tries_so_far == prmq_pkg::TRIES_MAX) ? prmq_pkg::TRIES_MAX
			: prmq_pkg::TRIES_BITS'(req.tries_so_far + 1'b1);
		cmd_in.op             = req.func;
		cmd_in.retry_ok       = (tries_inc < retry_limit);
		cmd_in.entry.mac      = req.node_mac;
		cmd_in.entry.payload  = req.payload_handle;
		cmd_in.entry.stamp    = req.now_ms;
		cmd_in.entry.urgent   = req.urgent;
		cmd_in.entry.tries    = (req.func == prmq_pkg::FUNC_RETRY) ? tries_inc : '0;
	end

	// Command queue between the front and the back.
	prmq_fifo #(
		.WIDTH ($bits(prmq_pkg::cmd_t)),
		.DEPTH (prmq_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (cmd_take),
		.rdata  (cmd_vec),
		.full   (full),
		.empty  (cmd_empty),
		.level  ()
	);

	assign cmd       = prmq_pkg::cmd_t'(cmd_vec);
	assign cmd_valid = !cmd_empty;

endmodule

>>> rtl/prmq_back.sv
// Back end: executes queued commands on the ring buffer, builds result beats
// and queues them. Depends on prmq_pkg, prmq_ram, prmq_fifo and the macro header.
`timescale 1ns / 1ps
`include "priority_retry_message_queue_macros.svh"

module prmq_back #(
	parameter int DEPTH = prmq_pkg::DEPTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  prmq_pkg::cmd_t                       cmd,
	input  logic                                 cmd_valid,
	output logic                                 cmd_take,
	input  logic [prmq_pkg::QLIMIT_BITS-1:0]     queue_limit,
	output prmq_pkg::result_t                    rsp,
	output logic                                 empty,
	input  logic                                 pop
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (CNT_W > prmq_pkg::QLIMIT_BITS) ? CNT_W : prmq_pkg::QLIMIT_BITS;
	localparam int RL_W  = $clog2(prmq_pkg::RES_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_WRAP = (IDX_W + 1)'(DEPTH);
	localparam logic [LIM_W-1:0] DEPTH_LIM  = LIM_W'(DEPTH);
	localparam logic [LIM_W-1:0] ONE_LIM    = LIM_W'(1);
	localparam logic [RL_W:0]    RES_ROOM   = (RL_W + 1)'(prmq_pkg::RES_DEPTH);

	// Ring state.
	logic [IDX_W-1:0]                  head_q, head_d;
	logic [CNT_W-1:0]                  count_q, count_d;
	logic [prmq_pkg::TOTAL_BITS-1:0]   drop_q, drop_d;
	logic [prmq_pkg::TOTAL_BITS-1:0]   recv_q, recv_d;

	// Derived ring values.
	logic [LIM_W-1:0]                  lim_raw;
	logic [LIM_W-1:0]                  limit;
	logic                              at_limit;
	logic [IDX_W-1:0]                  head_inc;
	logic [IDX_W-1:0]                  head_dec;
	logic [IDX_W:0]                    tail_sum;
	logic [IDX_W-1:0]                  tail;

	// Memory control.
	logic                              wr_en;
	logic [IDX_W-1:0]                  wr_addr;
	logic                              rd_en;
	logic [$bits(prmq_pkg::entry_t)-1:0] rd_vec;
	prmq_pkg::entry_t                  rd_entry;

	// Result stage and result queue.
	logic                              issue;
	prmq_pkg::status_t                 status_d;
	logic                              valid_s1;
	logic                              popped_s1;
	prmq_pkg::result_t                 res_s1;
	prmq_pkg::result_t                 res_out;
	logic                              res_full;
	logic [RL_W-1:0]                   res_level;
	logic [$bits(prmq_pkg::result_t)-1:0] rsp_vec;

	// Effective limit: zero acts as one, anything above the depth as the depth.
	always_comb begin
		lim_raw = LIM_W'(queue_limit);
		if (lim_raw == '0) begin
			limit = ONE_LIM;
		end else if (lim_raw > DEPTH_LIM) begin
			limit = DEPTH_LIM;
		end else begin
			limit = lim_raw;
		end
		at_limit = (LIM_W'(count_q) >= limit);
	end

	// Ring pointer arithmetic modulo the depth.
	always_comb begin
		head_inc = (head_q == LAST_IDX) ? '0 : IDX_W'(head_q + 1'b1);
		head_dec = (head_q == '0) ? LAST_IDX : IDX_W'(head_q - 1'b1);
		tail_sum = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(count_q);
		tail     = (tail_sum >= DEPTH_WRAP) ? IDX_W'(tail_sum - DEPTH_WRAP) : IDX_W'(tail_sum);
	end

	// Issue a command only while the result queue has room for it.
	assign issue    = cmd_valid &&
		(((RL_W + 1)'(res_level) + (RL_W + 1)'(valid_s1)) < RES_ROOM);
	assign cmd_take = issue;

	// Command execution.
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		drop_d   = drop_q;
		recv_d   = recv_q;
		status_d = prmq_pkg::STATUS_CLEARED;
		wr_en    = 1'b0;
		wr_addr  = tail;
		rd_en    = 1'b0;
		case (cmd.op)
			prmq_pkg::FUNC_ENQUEUE: begin
				wr_en  = issue;
				recv_d = recv_q + 1'b1;
				if (at_limit) begin
					// The front entry gives way; the count stays the same.
					drop_d   = drop_q + 1'b1;
					status_d = prmq_pkg::STATUS_QUEUED_DROP;
					if (cmd.entry.urgent) begin
						wr_addr = head_q;
					end else begin
						head_d = head_inc;
					end
				end else begin
					status_d = prmq_pkg::STATUS_QUEUED;
					count_d  = CNT_W'(count_q + 1'b1);
					if (cmd.entry.urgent) begin
						wr_addr = head_dec;
						head_d  = head_dec;
					end
				end
			end
			prmq_pkg::FUNC_DEQUEUE: begin
				if (count_q == '0) begin
					status_d = prmq_pkg::STATUS_EMPTY;
				end else begin
					status_d = prmq_pkg::STATUS_POPPED;
					rd_en    = issue;
					head_d   = head_inc;
					count_d  = CNT_W'(count_q - 1'b1);
				end
			end
			prmq_pkg::FUNC_RETRY: begin
				if (!cmd.retry_ok) begin
					drop_d   = drop_q + 1'b1;
					status_d = prmq_pkg::STATUS_EXHAUSTED;
				end else if (at_limit) begin
					drop_d   = drop_q + 1'b1;
					status_d = prmq_pkg::STATUS_REFUSED_FULL;
				end else begin
					wr_en    = issue;
					count_d  = CNT_W'(count_q + 1'b1);
					status_d = prmq_pkg::STATUS_REQUEUED;
				end
			end
			default: begin
				head_d   = '0;
				count_d  = '0;
				status_d = prmq_pkg::STATUS_CLEARED;
			end
		endcase
	end

	// Ring state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			drop_q  <= '0;
			recv_q  <= '0;
		end else if (issue) begin
			head_q  <= head_d;
			count_q <= count_d;
			drop_q  <= drop_d;
			recv_q  <= recv_d;
		end
	end

	// Message storage.
	prmq_ram #(
		.WIDTH ($bits(prmq_pkg::entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (cmd.entry),
		.re    (rd_en),
		.raddr (head_q),
		.rdata (rd_vec)
	);

	assign rd_entry = prmq_pkg::entry_t'(rd_vec);

	// Result stage: waits for the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			popped_s1             <= rd_en;
			res_s1.status         <= status_d;
			res_s1.out_mac        <= '0;
			res_s1.out_payload    <= '0;
			res_s1.out_time       <= '0;
			res_s1.out_tries      <= '0;
			res_s1.out_urgent     <= 1'b0;
			res_s1.fill_level     <= prmq_pkg::FILL_BITS'(count_d);
			res_s1.is_empty       <= (count_d == '0);
			res_s1.is_full        <= (LIM_W'(count_d) >= limit);
			res_s1.dropped_total  <= drop_d;
			res_s1.received_total <= recv_d;
		end
	end

	// Merge the popped message into the result beat.
	always_comb begin
		res_out = res_s1;
		if (popped_s1) begin
			res_out.out_mac     = rd_entry.mac;
			res_out.out_payload = rd_entry.payload;
			res_out.out_time    = rd_entry.stamp;
			res_out.out_tries   = rd_entry.tries;
			res_out.out_urgent  = rd_entry.urgent;
		end
	end

	// Result queue toward the consumer.
	prmq_fifo #(
		.WIDTH ($bits(prmq_pkg::result_t)),
		.DEPTH (prmq_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.wdata  (res_out),
		.pop    (pop),
		.rdata  (rsp_vec),
		.full   (res_full),
		.empty  (empty),
		.level  (res_level)
	);

	assign rsp = prmq_pkg::result_t'(rsp_vec);

	// The head pointer stays inside the ring, and the count never passes the depth.
	`PRMQ_ASSERT_SAME(a_head_in_ring, clk, arst_n, 1'b1, ({1'b0, head_q} < DEPTH_WRAP))
	`PRMQ_ASSERT_SAME(a_count_bounded, clk, arst_n, 1'b1, ((IDX_W + 1)'(count_q) <= DEPTH_WRAP))
	// The issue credit keeps a result beat from meeting a full result queue.
	`PRMQ_ASSERT_SAME(a_no_result_overflow, clk, arst_n, valid_s1, !res_full)
	// A clear leaves an empty ring rooted at slot zero.
	`PRMQ_ASSERT_NEXT(a_clear_resets_ring, clk, arst_n, (issue && (cmd.op == prmq_pkg::FUNC_CLEAR)), ((count_q == '0) && (head_q == '0)))

endmodule

>>> rtl/priority_retry_message_queue.sv
// A result beat passes the command queue and the result stage register before the result queue.
// Throughput: one beat per cycle while both queues have room; each issued command updates the ring head and count.
// The result stage exists to wait for the registered read of the message memory.
// Reset clears the ring pointers, the fill count and both totals; the queue limit returns to 16
// and the retry limit to 3. Stored messages are undefined until written; no clearing pass.
`timescale 1ns / 1ps

module priority_retry_message_queue #(
	parameter int DEPTH = prmq_pkg::DEPTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  prmq_pkg::in_item_t                     req,
	output logic                                   full,
	output prmq_pkg::result_t                      rsp,
	output logic                                   empty,
	input  logic                                   pop,
	input  logic                                   cfg_we,
	input  logic [0:0]                             cfg_index,
	input  logic [prmq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	logic [prmq_pkg::QLIMIT_BITS-1:0] queue_limit_q;
	logic [prmq_pkg::RLIMIT_BITS-1:0] retry_limit_q;
	prmq_pkg::cmd_t                   cmd;
	logic                             cmd_valid;
	logic                             cmd_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= prmq_pkg::QUEUE_LIMIT_RESET;
			retry_limit_q <= prmq_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_we) begin
			case (prmq_pkg::cfg_reg_t'(cfg_index))
				prmq_pkg::CFG_QUEUE_LIMIT: begin
					queue_limit_q <= cfg_data;
				end
				prmq_pkg::CFG_RETRY_LIMIT: begin
					retry_limit_q <= cfg_data[prmq_pkg::RLIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Decode and queue incoming beats.
	prmq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.req         (req),
		.full        (full),
		.retry_limit (retry_limit_q),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take)
	);

	// Execute commands on the ring and queue the results.
	prmq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take),
		.queue_limit (queue_limit_q),
		.rsp         (rsp),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

>>> verif/testbench.sv
// Self-checking testbench for priority_retry_message_queue: random and directed commands
// checked beat by beat against a behavioral queue predictor. Depends on prmq_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import prmq_pkg::*;

	localparam int RING_DEPTH  = DEPTH_DEFAULT;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 700000;
	localparam int PHASES      = 14;
	localparam int PHASE_CMDS  = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	in_item_t req = '0;
	logic full;
	result_t rsp;
	logic empty;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// Commands waiting to be driven and responses waiting to come back.
	in_item_t command_backlog[$];
	result_t awaited_responses[$];

	// Predictor copy of the queue state and the limit registers.
	entry_t ring [RING_DEPTH];
	int ring_head = 0;
	int ring_count = 0;
	logic [TOTAL_BITS-1:0] drops = '0;
	logic [TOTAL_BITS-1:0] receives = '0;
	logic [QLIMIT_BITS-1:0] qlimit_reg = QUEUE_LIMIT_RESET;
	logic [RLIMIT_BITS-1:0] rlimit_reg = RETRY_LIMIT_RESET;

	int cmds_issued = 0;
	int cmds_accepted = 0;
	int beats_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int status_seen [8];
	int idle_left = 0;
	int stall_left = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	priority_retry_message_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one command to the predicted queue and return the response it should produce.
	function automatic result_t next_queue_response(input in_item_t cmd);
		result_t r;
		entry_t e;
		int lim;
		int t;
		r = '0;
		lim = (qlimit_reg == 0) ? 1
			: ((qlimit_reg > RING_DEPTH) ? RING_DEPTH : int'(qlimit_reg));
		e.mac = cmd.node_mac;
		e.payload = cmd.payload_handle;
		e.stamp = cmd.now_ms;
		e.tries = '0;
		e.urgent = cmd.urgent;
		case (cmd.func)
			FUNC_ENQUEUE: begin
				r.status = STATUS_QUEUED;
				// A full queue loses its front entry first.
				if (ring_count >= lim) begin
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_count--;
					drops++;
					r.status = STATUS_QUEUED_DROP;
				end
				if (cmd.urgent) begin
					ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
					ring[ring_head] = e;
				end else begin
					ring[(ring_head + ring_count) % RING_DEPTH] = e;
				end
				ring_count++;
				receives++;
			end
			FUNC_DEQUEUE: begin
				if (ring_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					e = ring[ring_head];
					r.out_mac = e.mac;
					r.out_payload = e.payload;
					r.out_time = e.stamp;
					r.out_tries = e.tries;
					r.out_urgent = e.urgent;
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_count--;
					r.status = STATUS_POPPED;
				end
			end
			FUNC_RETRY: begin
				// The retry count saturates at its top value.
				t = int'(cmd.tries_so_far);
				if (t < TRIES_MAX)
					t++;
				if (t < rlimit_reg) begin
					if (ring_count >= lim) begin
						drops++;
						r.status = STATUS_REFUSED_FULL;
					end else begin
						e.tries = TRIES_BITS'(t);
						ring[(ring_head + ring_count) % RING_DEPTH] = e;
						ring_count++;
						r.status = STATUS_REQUEUED;
					end
				end else begin
					drops++;
					r.status = STATUS_EXHAUSTED;
				end
			end
			FUNC_CLEAR: begin
				ring_count = 0;
				ring_head = 0;
				r.status = STATUS_CLEARED;
			end
		endcase
		r.fill_level = FILL_BITS'(ring_count);
		r.is_empty = (ring_count == 0);
		r.is_full = (ring_count >= lim);
		r.dropped_total = drops;
		r.received_total = receives;
		return r;
	endfunction

	// Mostly short gaps, a few long ones, none at all during steady phases.
	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic in_item_t make_cmd(input func_t f, input logic [MAC_BITS-1:0] mac,
			input logic [PAYLOAD_BITS-1:0] pay, input logic urg,
			input logic [TRIES_BITS-1:0] tries, input logic [TIME_BITS-1:0] stamp);
		in_item_t c;
		c.func = f;
		c.node_mac = mac;
		c.payload_handle = pay;
		c.urgent = urg;
		c.tries_so_far = tries;
		c.now_ms = stamp;
		return c;
	endfunction

	// Random content; addresses sometimes sit at the extremes, retry counts lean low.
	function automatic in_item_t random_cmd(input func_t f);
		logic [63:0] wide;
		logic [TRIES_BITS-1:0] tries;
		int roll;
		wide = {$urandom, $urandom};
		roll = $urandom_range(0, 15);
		if (roll == 0)
			wide = '0;
		else if (roll == 1)
			wide = '1;
		tries = $urandom_range(0, 1) ? TRIES_BITS'($urandom_range(0, 15))
			: TRIES_BITS'($urandom_range(0, 3));
		return make_cmd(f, wide[MAC_BITS-1:0], $urandom, 1'($urandom_range(0, 1)), tries,
			$urandom);
	endfunction

	task automatic issue(input in_item_t cmd);
		command_backlog.insert(command_backlog.size(), cmd);
		cmds_issued++;
	endtask

	// Wait until every command is accepted and every response is back.
	task automatic wait_idle();
		while (command_backlog.size() != 0 || cmds_accepted != cmds_issued ||
				awaited_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limits(input logic [QLIMIT_BITS-1:0] q, input logic [RLIMIT_BITS-1:0] r);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_QUEUE_LIMIT;
		cfg_data <= q;
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= {1'b0, r};
		@(posedge clk);
		cfg_we <= 1'b0;
		qlimit_reg = q;
		rlimit_reg = r;
		settings_used++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want, inout bit bad);
		if (got !== want) begin
			bad = 1'b1;
			if (mismatches < 10)
				$display("Mismatch on beat %0d, %s: expected %h, got %h",
					beats_checked, name, want, got);
		end
	endtask

	// Command driver: predicts each accepted beat, then offers the next one after a gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				awaited_responses.insert(awaited_responses.size(), next_queue_response(req));
				cmds_accepted++;
				idle_left = draw_gap();
			end
			if (push && full) begin
				// Hold the current beat until it is taken.
			end else if (idle_left > 0) begin
				idle_left--;
				push <= 1'b0;
			end else if (command_backlog.size() > 0) begin
				req <= command_backlog.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Response monitor: compares each accepted beat with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		bit bad;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited_responses.size() == 0) begin
					if (mismatches < 10)
						$display("Response beat %0d arrived with none predicted, status %0d",
							beats_checked, rsp.status);
					mismatches++;
				end else begin
					want = awaited_responses.pop_front();
					bad = 1'b0;
					check_field("status", rsp.status, want.status, bad);
					check_field("out_mac", rsp.out_mac, want.out_mac, bad);
					check_field("out_payload", rsp.out_payload, want.out_payload, bad);
					check_field("out_time", rsp.out_time, want.out_time, bad);
					check_field("out_tries", rsp.out_tries, want.out_tries, bad);
					check_field("out_urgent", rsp.out_urgent, want.out_urgent, bad);
					check_field("fill_level", rsp.fill_level, want.fill_level, bad);
					check_field("is_empty", rsp.is_empty, want.is_empty, bad);
					check_field("is_full", rsp.is_full, want.is_full, bad);
					check_field("dropped_total", rsp.dropped_total, want.dropped_total, bad);
					check_field("received_total", rsp.received_total, want.received_total, bad);
					if (bad)
						mismatches++;
				end
				status_seen[int'(rsp.status)]++;
				beats_checked++;
				stall_left = draw_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d responses outstanding",
			cycle_count, awaited_responses.size());
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus: directed corner cases, then random phases under varied limits.
	initial begin
		logic [QLIMIT_BITS-1:0] q;
		logic [RLIMIT_BITS-1:0] r;
		int enq_pct;
		int roll;
		func_t f;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: empty pop, all-ones message, retry counts around the limit and at the top.
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));
		issue(make_cmd(FUNC_ENQUEUE, '1, '1, 1'b0, '1, '1));
		issue(make_cmd(FUNC_RETRY, 48'h0123_4567_89AB, 32'h5555_AAAA, 1'b1, 4'd1, 32'd7));
		issue(make_cmd(FUNC_RETRY, '1, '1, 1'b1, 4'd2, '1));
		issue(make_cmd(FUNC_RETRY, '1, '1, 1'b0, TRIES_MAX, '1));
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));
		issue(make_cmd(FUNC_CLEAR, '1, '1, 1'b1, '1, '1));

		// Limit of two: urgent to the front, drop on full, retry refused while full.
		set_limits(5'd2, 4'd3);
		issue(make_cmd(FUNC_ENQUEUE, '0, '0, 1'b1, '0, '0));
		issue(make_cmd(FUNC_ENQUEUE, 48'hAAAA_5555_AAAA, 32'h1234_5678, 1'b0, '0, 32'd100));
		issue(make_cmd(FUNC_ENQUEUE, 48'h5555_AAAA_5555, 32'h8765_4321, 1'b1, '0, 32'd200));
		issue(make_cmd(FUNC_RETRY, 48'h1111_2222_3333, 32'h4444_5555, 1'b0, 4'd0, 32'd300));
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));
		issue(make_cmd(FUNC_RETRY, 48'h7777_8888_9999, 32'hAAAA_BBBB, 1'b1, 4'd0, 32'd400));
		issue(make_cmd(FUNC_CLEAR, '0, '0, 1'b0, '0, '0));
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));

		// Queue limit zero acts as one; retry limit zero exhausts every retry.
		set_limits(5'd0, 4'd0);
		issue(make_cmd(FUNC_ENQUEUE, 48'hDEAD_BEEF_0001, 32'd1, 1'b0, '0, 32'd1));
		issue(make_cmd(FUNC_ENQUEUE, 48'hDEAD_BEEF_0002, 32'd2, 1'b0, '0, 32'd2));
		issue(make_cmd(FUNC_RETRY, 48'hDEAD_BEEF_0003, 32'd3, 1'b0, 4'd0, 32'd3));

		// Limit above the depth acts as the depth; then a lowered limit drops only one entry.
		set_limits(5'd31, 4'd15);
		issue(make_cmd(FUNC_CLEAR, '0, '0, 1'b0, '0, '0));
		repeat (5) issue(random_cmd(FUNC_ENQUEUE));
		set_limits(5'd3, 4'd15);
		issue(make_cmd(FUNC_ENQUEUE, 48'hCAFE_0000_0001, 32'h0F0F_0F0F, 1'b1, '0, 32'd500));
		issue(make_cmd(FUNC_RETRY, 48'hCAFE_0000_0002, 32'hF0F0_F0F0, 1'b0, 4'd13, 32'd600));
		issue(make_cmd(FUNC_DEQUEUE, '0, '0, 1'b0, '0, '0));

		// Random phases; the first few take the extreme limit settings.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin q = 5'd1; r = 4'd1; end
				1: begin q = 5'd16; r = 4'd15; end
				2: begin q = 5'd31; r = 4'd15; end
				3: begin q = 5'd0; r = 4'd0; end
				4: begin q = 5'd17; r = 4'd1; end
				default: begin
					q = $urandom_range(0, 7) == 0 ? QLIMIT_BITS'($urandom_range(0, 31))
						: QLIMIT_BITS'($urandom_range(1, 16));
					r = RLIMIT_BITS'($urandom_range(0, 15));
				end
			endcase
			set_limits(q, r);
			steady = (p % 4 == 3);
			enq_pct = $urandom_range(25, 60);
			repeat (PHASE_CMDS) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					f = FUNC_CLEAR;
				else if (roll < 22)
					f = FUNC_RETRY;
				else if (roll < 22 + enq_pct)
					f = FUNC_ENQUEUE;
				else
					f = FUNC_DEQUEUE;
				issue(random_cmd(f));
			end
		end

		wait_idle();
		$display("Checked %0d response beats over %0d limit settings:",
			beats_checked, settings_used);
		$display("%0d queued, %0d after a drop, %0d popped, %0d empty,",
			status_seen[STATUS_QUEUED], status_seen[STATUS_QUEUED_DROP],
			status_seen[STATUS_POPPED], status_seen[STATUS_EMPTY]);
		$display("%0d requeued, %0d exhausted, %0d refused, %0d cleared.",
			status_seen[STATUS_REQUEUED], status_seen[STATUS_EXHAUSTED],
			status_seen[STATUS_REFUSED_FULL], status_seen[STATUS_CLEARED]);
		if (mismatches == 0 && awaited_responses.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatching beats, %0d responses never arrived",
				mismatches, awaited_responses.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
